@@ design/gda_pkg.sv @@
// gda_pkg: shared types, codes, constants and calendar tables for the
// gregorian date arithmetic block. No dependencies.
`default_nettype none

package gda_pkg;

  localparam int unsigned MAX_YEAR_DEF = 9999;
  localparam int unsigned DAYS_W       = 22;
  localparam int unsigned DAYS_MAX     = 4194303;
  // stages inside the day-number-to-date converter, and end to end latency
  localparam int unsigned FROM_LAT     = 8;
  localparam int unsigned GDA_LAT      = FROM_LAT + 4;

  localparam logic [1:0] MODE_ADD  = 2'd0;
  localparam logic [1:0] MODE_SUB  = 2'd1;
  localparam logic [1:0] MODE_DIFF = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [21:0] day_count;
    logic [4:0]  other_day;
    logic [3:0]  other_month;
    logic [13:0] other_year;
  } gda_in_t;

  typedef struct packed {
    logic [4:0]  result_day;
    logic [3:0]  result_month;
    logic [13:0] result_year;
    logic [21:0] days_between;
    logic [1:0]  status;
  } gda_out_t;

  // days before month m in a common year
  function automatic logic [8:0] cum_days(input logic [3:0] m);
    logic [8:0] r;
    case (m)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] r;
    case (m)
      4'd2:    r = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
      default: r = 5'd31;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ design/gregorian_date_arithmetic.sv @@
// gregorian_date_arithmetic: top level, add/subtract days and date difference.
// Depends on gda_pkg, gda_dnum, gda_dfrom.
//
//   channel   signals               transfer when
//   request   start, busy, request  start && !busy
//   result    done, result          done (one cycle, cannot be held off)
//
// Fully pipelined: a request can enter every cycle; its result passes
// through 2 day-number stages, 1 arithmetic stage, 8 date stages and
// 1 output stage. busy is high only during reset.
// Reset clears the valid bits of every stage; no reset-time sweep.
// The receiver cannot stall, so nothing in the pipeline ever waits.
`default_nettype none

module gregorian_date_arithmetic #(
  parameter int unsigned MAX_YEAR = gda_pkg::MAX_YEAR_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire gda_pkg::gda_in_t request,
  output logic                  done,
  output gda_pkg::gda_out_t     result
);
  import gda_pkg::*;

  localparam longint unsigned LastDay = 365 * longint'(MAX_YEAR) + MAX_YEAR / 4 -
                                        MAX_YEAR / 100 + MAX_YEAR / 400;
  localparam int unsigned DNW = $clog2(LastDay + 1);
  localparam int unsigned QW  = $clog2(LastDay / 146097 + 1);
  localparam int unsigned YW  = $clog2(MAX_YEAR + 1);

  logic           acc;
  logic           v1, v2, v3;
  logic [1:0]     mode1, mode2;
  logic [21:0]    cnt1, cnt2;
  logic [DNW-1:0] dn_a, dn_b;
  logic           ok_a, ok_b;

  logic [DNW-1:0] n_next;
  logic [1:0]     st_next;
  logic [21:0]    btw_next;
  logic           zero_next;
  logic [31:0]    sum, diff;

  logic [DNW-1:0] n3;
  logic [1:0]     st_d   [FROM_LAT+1];
  logic [21:0]    btw_d  [FROM_LAT+1];
  logic           zero_d [FROM_LAT+1];

  logic           f_valid;
  logic [4:0]     f_day;
  logic [3:0]     f_month;
  logic [YW-1:0]  f_year;

  assign busy = rst;
  assign acc  = start && !busy;

  gda_dnum #(.MAX_YEAR(MAX_YEAR), .DNW(DNW)) u_dnum_a (
    .clk(clk), .d(request.day), .m(request.month), .y(request.year),
    .dn(dn_a), .ok(ok_a)
  );

  gda_dnum #(.MAX_YEAR(MAX_YEAR), .DNW(DNW)) u_dnum_b (
    .clk(clk), .d(request.other_day), .m(request.other_month),
    .y(request.other_year), .dn(dn_b), .ok(ok_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= acc;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    mode1 <= request.mode;
    cnt1  <= request.day_count;
    mode2 <= mode1;
    cnt2  <= cnt1;
  end

  always_comb begin
    n_next    = DNW'(1);
    st_next   = ST_OK;
    btw_next  = '0;
    zero_next = 1'b0;
    sum       = 32'(dn_a) + 32'(cnt2);
    diff      = (dn_a > dn_b) ? 32'(dn_a - dn_b) : 32'(dn_b - dn_a);
    if ((mode2 != MODE_ADD && mode2 != MODE_SUB && mode2 != MODE_DIFF) ||
        !ok_a || (mode2 == MODE_DIFF && !ok_b)) begin
      st_next   = ST_INVALID;
      zero_next = 1'b1;
    end else if (mode2 == MODE_DIFF) begin
      zero_next = 1'b1;
      if (diff > 32'(DAYS_MAX)) begin
        btw_next = 22'(DAYS_MAX);
        st_next  = ST_RANGE;
      end else begin
        btw_next = 22'(diff);
      end
    end else if (mode2 == MODE_ADD) begin
      if (sum > 32'(LastDay)) begin
        n_next  = DNW'(LastDay);
        st_next = ST_RANGE;
      end else begin
        n_next = DNW'(sum);
      end
    end else begin
      // going back past the first day clamps to day one
      if (32'(cnt2) >= 32'(dn_a)) begin
        st_next = ST_RANGE;
      end else begin
        n_next = dn_a - DNW'(cnt2);
      end
    end
  end

  always_ff @(posedge clk) begin
    n3        <= n_next;
    st_d[0]   <= st_next;
    btw_d[0]  <= btw_next;
    zero_d[0] <= zero_next;
    for (int i = 1; i <= FROM_LAT; i++) begin
      st_d[i]   <= st_d[i-1];
      btw_d[i]  <= btw_d[i-1];
      zero_d[i] <= zero_d[i-1];
    end
  end

  gda_dfrom #(.DNW(DNW), .QW(QW), .YW(YW)) u_dfrom (
    .clk(clk), .rst(rst), .in_valid(v3), .n(n3),
    .out_valid(f_valid), .day(f_day), .month(f_month), .year(f_year)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= f_valid;
    end
  end

  always_ff @(posedge clk) begin
    result.status       <= st_d[FROM_LAT];
    result.days_between <= btw_d[FROM_LAT];
    if (zero_d[FROM_LAT]) begin
      result.result_day   <= '0;
      result.result_month <= '0;
      result.result_year  <= '0;
    end else begin
      result.result_day   <= f_day;
      result.result_month <= f_month;
      result.result_year  <= 14'(f_year);
    end
  end

endmodule

`default_nettype wire

@@ design/gda_dnum.sv @@
// gda_dnum: two-stage conversion of a date to its day number (0001-01-01 is 1)
// with validity check. Depends on gda_pkg.
`default_nettype none

module gda_dnum #(
  parameter int unsigned MAX_YEAR = gda_pkg::MAX_YEAR_DEF,
  parameter int unsigned DNW      = 22
) (
  input  wire logic           clk,
  input  wire logic [4:0]     d,
  input  wire logic [3:0]     m,
  input  wire logic [13:0]    y,
  output logic [DNW-1:0]      dn,
  output logic                ok
);
  import gda_pkg::*;

  logic        range_ok;
  logic [4:0]  d1;
  logic [3:0]  m1;
  logic [13:0] y1;
  logic [22:0] p365;
  logic [11:0] pq4;
  logic [7:0]  pq100;
  logic [7:0]  yq100;
  logic [13:0] p;
  logic        leap;
  logic [23:0] sum;

  assign p = y - 14'd1;

  // x/100 as (x*5243)>>19, exact for these widths
  always_ff @(posedge clk) begin
    range_ok <= (m >= 4'd1) && (m <= 4'd12) && (y != 14'd0) &&
                (32'(y) <= 32'(MAX_YEAR)) && (d != 5'd0);
    d1    <= d;
    m1    <= m;
    y1    <= y;
    p365  <= 23'(p) * 23'd365;
    pq4   <= p[13:2];
    pq100 <= 8'((28'(p) * 28'd5243) >> 19);
    yq100 <= 8'((28'(y) * 28'd5243) >> 19);
  end

  always_comb begin
    leap = (y1[1:0] == 2'd0) &&
           ((14'(yq100) * 14'd100 != y1) || (yq100[1:0] == 2'd0));
    sum  = 24'(p365) + 24'(pq4) - 24'(pq100) + 24'(pq100[7:2]) +
           24'(cum_days(m1)) + 24'(leap && (m1 > 4'd2)) + 24'(d1);
  end

  always_ff @(posedge clk) begin
    ok <= range_ok && (d1 <= month_len(m1, leap));
    dn <= DNW'(sum);
  end

endmodule

`default_nettype wire

@@ design/gda_dfrom.sv @@
// gda_dfrom: pipelined conversion of a day number back to day, month and year
// through 400, 100, 4 and 1 year cycles. Depends on gda_pkg.
`default_nettype none

module gda_dfrom #(
  parameter int unsigned DNW = 22,
  parameter int unsigned QW  = 7,
  parameter int unsigned YW  = 14
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire logic [DNW-1:0] n,
  output logic               out_valid,
  output logic [4:0]         day,
  output logic [3:0]         month,
  output logic [YW-1:0]      year
);
  import gda_pkg::*;

  localparam int unsigned D400 = 146097;
  localparam int unsigned D100 = 36524;
  localparam int unsigned D4   = 1461;

  logic [FROM_LAT-1:0] v;

  logic [DNW-1:0]    r_f1;
  logic [QW-1:0]     q_f1;
  logic [DNW+14:0]   prod_f1;
  logic [DNW-1:0]    rem_f2;
  logic [QW-1:0]     q_f2;
  logic [17:0]       rem_f3;
  logic [QW-1:0]     q_f3;
  logic [1:0]        c_f4;
  logic [15:0]       r2_f4;
  logic [YW-1:0]     yb_f4;
  logic [1:0]        c4;
  logic [1:0]        c_f5;
  logic [15:0]       r2_f5;
  logic [4:0]        q4_f5;
  logic [YW-1:0]     yb_f5;
  logic [1:0]        c_f6;
  logic [11:0]       r3_f6;
  logic [4:0]        q4_f6;
  logic [YW-1:0]     yb_f6;
  logic [11:0]       r3c;
  logic [4:0]        q4c;
  logic [1:0]        a7;
  logic [8:0]        r4_f7;
  logic [YW-1:0]     yr_f7;
  logic              leap_f7;
  logic [3:0]        mon;
  logic [9:0]        mstart;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= {v[FROM_LAT-2:0], in_valid};
    end
  end

  assign out_valid = v[FROM_LAT-1];
  assign prod_f1   = (DNW+15)'(n - DNW'(1)) * (DNW+15)'(29398);

  // 400 year cycle: estimate by reciprocal, low by at most one
  always_ff @(posedge clk) begin
    r_f1 <= n - DNW'(1);
    q_f1 <= QW'(prod_f1 >> 32);
  end

  always_ff @(posedge clk) begin
    rem_f2 <= r_f1 - DNW'(32'(q_f1) * 32'(D400));
    q_f2   <= q_f1;
  end

  always_ff @(posedge clk) begin
    if (32'(rem_f2) >= 32'(D400)) begin
      rem_f3 <= 18'(32'(rem_f2) - 32'(D400));
      q_f3   <= q_f2 + QW'(1);
    end else begin
      rem_f3 <= 18'(rem_f2);
      q_f3   <= q_f2;
    end
  end

  // century, last one of the cycle is a day longer
  always_comb begin
    if (rem_f3 >= 18'(3 * D100)) c4 = 2'd3;
    else if (rem_f3 >= 18'(2 * D100)) c4 = 2'd2;
    else if (rem_f3 >= 18'(D100)) c4 = 2'd1;
    else c4 = 2'd0;
  end

  always_ff @(posedge clk) begin
    c_f4  <= c4;
    r2_f4 <= 16'(rem_f3 - 18'(c4) * 18'(D100));
    yb_f4 <= YW'(32'(q_f3) * 32'd400 + 32'(c4) * 32'd100);
  end

  always_ff @(posedge clk) begin
    c_f5  <= c_f4;
    r2_f5 <= r2_f4;
    q4_f5 <= 5'((26'(r2_f4) * 26'd717) >> 20);
    yb_f5 <= yb_f4;
  end

  always_ff @(posedge clk) begin
    c_f6  <= c_f5;
    r3_f6 <= 12'(r2_f5 - 16'(q4_f5) * 16'(D4));
    q4_f6 <= q4_f5;
    yb_f6 <= yb_f5;
  end

  always_comb begin
    if (r3_f6 >= 12'(D4)) begin
      r3c = r3_f6 - 12'(D4);
      q4c = q4_f6 + 5'd1;
    end else begin
      r3c = r3_f6;
      q4c = q4_f6;
    end
    if (r3c >= 12'd1095) a7 = 2'd3;
    else if (r3c >= 12'd730) a7 = 2'd2;
    else if (r3c >= 12'd365) a7 = 2'd1;
    else a7 = 2'd0;
  end

  // leap: year is last of a 4 year group, and not a century unless 400th
  always_ff @(posedge clk) begin
    r4_f7   <= 9'(r3c - 12'(a7) * 12'd365);
    yr_f7   <= yb_f6 + YW'(q4c) * YW'(4) + YW'(a7) + YW'(1);
    leap_f7 <= (a7 == 2'd3) && ((q4c != 5'd24) || (c_f6 == 2'd3));
  end

  always_comb begin
    mon = 4'd1;
    for (int k = 2; k <= 12; k++) begin
      if (10'(r4_f7) >= 10'(cum_days(4'(k))) + 10'(leap_f7 && (k > 2))) begin
        mon = mon + 4'd1;
      end
    end
    mstart = 10'(cum_days(mon)) + 10'(leap_f7 && (mon > 4'd2));
  end

  always_ff @(posedge clk) begin
    month <= mon;
    day   <= 5'(10'(r4_f7) - mstart + 10'd1);
    year  <= yr_f7;
  end

endmodule

`default_nettype wire

@@ design/gda_checker.sv @@
// gda_checker: port-level assertions for gregorian_date_arithmetic, bound
// to the top level. Depends on gda_pkg.
`default_nettype none

module gda_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              done,
  input wire gda_pkg::gda_out_t result
);
  import gda_pkg::*;

  // every result comes from a transfer a fixed latency earlier
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, GDA_LAT))
    else $error("result without matching request");

  a_status: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.status == ST_OK || result.status == ST_INVALID ||
              result.status == ST_RANGE))
    else $error("bad status code");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    done && result.status == ST_INVALID |->
      result.result_day == 5'd0 && result.result_month == 4'd0 &&
      result.result_year == 14'd0 && result.days_between == 22'd0)
    else $error("invalid request with nonzero fields");

  a_one_kind: assert property (@(posedge clk) disable iff (rst)
    done && result.days_between != 22'd0 |-> result.result_day == 5'd0)
    else $error("date and difference both present");

  a_month: assert property (@(posedge clk) disable iff (rst)
    done && result.result_day != 5'd0 |->
      result.result_month >= 4'd1 && result.result_month <= 4'd12)
    else $error("month out of range");

endmodule

bind gregorian_date_arithmetic gda_checker u_gda_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done), .result(result)
);

`default_nettype wire
